// ----- design/lda_pkg.sv -----
// Shared types and constants for the lens distortion pipeline.
package lda_pkg;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [23:0] FOCAL_RESET = 24'd5980160;
  localparam logic [15:0] CX_RESET    = 16'd4096;
  localparam logic [15:0] CY_RESET    = 16'd3392;

  localparam int QUO_W        = 32;
  localparam int DIV_BITS     = 4;
  localparam int DIV_STAGES   = QUO_W / DIV_BITS;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [39:0] Q_ONE   = 40'sd268435456;

  typedef enum logic [2:0] {
    REG_FOCAL_X   = 3'd0,
    REG_FOCAL_Y   = 3'd1,
    REG_PRINCIPAL = 3'd2,
    REG_K1        = 3'd3,
    REG_K2        = 3'd4,
    REG_K3        = 3'd5,
    REG_P1        = 3'd6,
    REG_P2        = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic        [23:0] focal_x;
    logic        [23:0] focal_y;
    logic        [15:0] cx;
    logic        [15:0] cy;
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] k3;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
  } cfg_t;

  // one axis of the restoring divider
  typedef struct packed {
    logic [23:0]      rem;
    logic [QUO_W-1:0] quo;
    logic             neg;
    logic             big;
  } div_lane_t;

  typedef struct packed {
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic               flag;
    logic               zero;
  } norm_t;

endpackage

// ----- design/lda_if.sv -----
// Stream interfaces for pixel input and warped output.
interface lda_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pixel_x;
  logic signed [15:0] pixel_y;
  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface lda_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] warped_x;
  logic signed [15:0] warped_y;
  logic               saturated;
  modport source (output valid, warped_x, warped_y, saturated, input ready);
  modport sink   (input valid, warped_x, warped_y, saturated, output ready);
endinterface

// ----- design/lens_distortion_apply_top.sv -----
// Top level of the Brown-Conrady lens distortion pipeline.
// Usage:
//  - pix_in carries one undistorted pixel (pixel_x, pixel_y, signed Q12.4) per beat;
//    pix_out returns its distorted position (warped_x, warped_y) and a saturated flag.
//  - Intrinsics and coefficients sit in an APB register file (focal_x, focal_y,
//    principal_point, k1, k2, k3, p1, p2 at byte offsets 0x00..0x1C). Write them
//    only while no beat is in flight.
//  - Throughput: one beat per clock while pix_out is not stalled. 24 register
//    stages in all: 10 in the normalisation front end (offset, 8 divider stages
//    of 4 quotient bits each, sign/clamp) and 14 in the polynomial back end (a
//    32x32 multiply level, an add/saturate level, or both, per stage).
//  - Reset clears every stage valid bit and loads the register defaults;
//    no beat comes out until one has gone in.
//  - A stall on pix_out holds the last stage; upstream stages keep filling
//    bubbles, so pix_in stays ready until the whole pipe is full.
//  - A zero focal length yields (0, 0) with saturated set.
module lens_distortion_apply_top
  import lda_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  lda_in_if.sink                pix_in,
  lda_out_if.source             pix_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t  cfg;
  logic  norm_valid;
  logic  norm_ready;
  norm_t norm_data;

  lda_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // offset and divide: dx = (px - cx) / fx in Q4.28
  lda_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .px        (pix_in.pixel_x),
    .py        (pix_in.pixel_y),
    .out_valid (norm_valid),
    .out_ready (norm_ready),
    .out_data  (norm_data)
  );

  // radial and tangential terms, then back to pixels
  lda_warp u_warp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (norm_valid),
    .in_ready  (norm_ready),
    .in_data   (norm_data),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .warped_x  (pix_out.warped_x),
    .warped_y  (pix_out.warped_y),
    .saturated (pix_out.saturated)
  );

  // an empty output stage must never block the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !pix_out.valid |-> pix_in.ready)
    else $error("input stalled with empty output stage");

  // reset drains the pipe
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !pix_out.valid)
    else $error("output valid right after reset");

  // a beat held between front and back ends is not dropped
  a_mid_hold: assert property (@(posedge clk) disable iff (rst)
    norm_valid && !norm_ready |=> norm_valid)
    else $error("mid-pipe beat lost under stall");

endmodule

// ----- design/lda_cfg.sv -----
// APB register file holding camera intrinsics and distortion coefficients.
module lda_cfg
  import lda_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_reg_e sel;

  assign sel    = cfg_reg_e'(paddr[CFG_ADDR_W-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal_x <= FOCAL_RESET;
      cfg.focal_y <= FOCAL_RESET;
      cfg.cx      <= CX_RESET;
      cfg.cy      <= CY_RESET;
      cfg.k1      <= '0;
      cfg.k2      <= '0;
      cfg.k3      <= '0;
      cfg.p1      <= '0;
      cfg.p2      <= '0;
    end else if (psel && penable && pwrite) begin
      case (sel)
        REG_FOCAL_X:   cfg.focal_x <= pwdata[23:0];
        REG_FOCAL_Y:   cfg.focal_y <= pwdata[23:0];
        REG_PRINCIPAL: begin
          cfg.cx <= pwdata[15:0];
          cfg.cy <= pwdata[31:16];
        end
        REG_K1:        cfg.k1 <= $signed(pwdata);
        REG_K2:        cfg.k2 <= $signed(pwdata);
        REG_K3:        cfg.k3 <= $signed(pwdata);
        REG_P1:        cfg.p1 <= $signed(pwdata);
        REG_P2:        cfg.p2 <= $signed(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_FOCAL_X:   prdata = {8'd0, cfg.focal_x};
      REG_FOCAL_Y:   prdata = {8'd0, cfg.focal_y};
      REG_PRINCIPAL: prdata = {cfg.cy, cfg.cx};
      REG_K1:        prdata = cfg.k1;
      REG_K2:        prdata = cfg.k2;
      REG_K3:        prdata = cfg.k3;
      REG_P1:        prdata = cfg.p1;
      REG_P2:        prdata = cfg.p2;
      default:       prdata = '0;
    endcase
  end

endmodule

// ----- design/lda_norm.sv -----
// Normalisation front end: centre offset and pipelined restoring divide by focal length.
module lda_norm
  import lda_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] px,
  input  logic signed [15:0] py,
  output logic               out_valid,
  input  logic               out_ready,
  output norm_t              out_data
);

  localparam int NS = DIV_STAGES + 2;

  typedef struct packed {
    div_lane_t x;
    div_lane_t y;
    logic      zero;
  } nst_t;

  nst_t            st [NS-1];
  logic [NS-1:0]   v;
  logic [NS-1:0]   en;

  // |d| << 38 plus f/2: the top 24 bits are |d| << 6, the low 32 bits are f >> 1
  function automatic div_lane_t prep(logic signed [15:0] p, logic [15:0] c,
                                     logic [23:0] f);
    logic signed [17:0] d;
    logic        [17:0] mag;
    logic        [23:0] top;
    div_lane_t          l;
    d     = 18'(p) - $signed({2'b00, c});
    mag   = d[17] ? 18'(-d) : 18'(d);
    top   = {1'b0, mag[16:0], 6'd0};
    l.neg = d[17];
    l.big = (top >= f);
    l.rem = top;
    l.quo = '0;
    return l;
  endfunction

  function automatic div_lane_t div_step(div_lane_t a, logic [23:0] f, int k);
    logic [24:0]      t;
    logic [23:0]      r;
    logic [QUO_W-1:0] q;
    logic [QUO_W-1:0] nlow;
    logic [4:0]       b;
    div_lane_t        l;
    nlow = {9'd0, f[23:1]};
    r    = a.rem;
    q    = a.quo;
    for (int j = 0; j < DIV_BITS; j++) begin
      b = 5'(QUO_W - 1 - k * DIV_BITS - j);
      t = {r, nlow[b]};
      if (t >= {1'b0, f}) begin
        r    = 24'(t - {1'b0, f});
        q[b] = 1'b1;
      end else begin
        r = t[23:0];
      end
    end
    l     = a;
    l.rem = r;
    l.quo = q;
    return l;
  endfunction

  // sign and clamp to Q4.28; -2^31 is still representable
  function automatic logic [32:0] finish(div_lane_t a);
    logic               ovf;
    logic signed [31:0] val;
    if (a.neg) begin
      ovf = a.big || (a.quo[31] && (|a.quo[30:0]));
      val = ovf ? S32_MIN : $signed(32'(32'd0 - a.quo));
    end else begin
      ovf = a.big || a.quo[31];
      val = ovf ? S32_MAX : $signed(a.quo);
    end
    return {ovf, val};
  endfunction

  always_comb begin
    en[NS-1] = !v[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [32:0] fx;
    logic [32:0] fy;
    fx = finish(st[NS-2].x);
    fy = finish(st[NS-2].y);
    if (en[0]) begin
      st[0].x    <= prep(px, cfg.cx, cfg.focal_x);
      st[0].y    <= prep(py, cfg.cy, cfg.focal_y);
      st[0].zero <= (cfg.focal_x == '0) || (cfg.focal_y == '0);
    end
    for (int k = 1; k < NS - 1; k++) begin
      if (en[k]) begin
        st[k].x    <= div_step(st[k-1].x, cfg.focal_x, k - 1);
        st[k].y    <= div_step(st[k-1].y, cfg.focal_y, k - 1);
        st[k].zero <= st[k-1].zero;
      end
    end
    if (en[NS-1]) begin
      out_data.dx   <= $signed(fx[31:0]);
      out_data.dy   <= $signed(fy[31:0]);
      out_data.flag <= fx[32] || fy[32];
      out_data.zero <= st[NS-2].zero;
    end
  end

endmodule

// ----- design/lda_warp.sv -----
// Distortion polynomial and pixel mapping, at most one multiply level per stage.
module lda_warp
  import lda_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  norm_t              in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] warped_x,
  output logic signed [15:0] warped_y,
  output logic               saturated
);

  localparam int NS = 14;

  typedef struct packed {
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dx2;
    logic signed [31:0] dy2;
    logic signed [31:0] dxdy2;
    logic signed [31:0] r2;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] t;
    logic signed [31:0] kr;
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic signed [63:0] m0;
    logic signed [63:0] m1;
    logic signed [63:0] m2;
    logic signed [63:0] m3;
    logic signed [63:0] m4;
    logic signed [63:0] m5;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic               flag;
    logic               zero;
  } wst_t;

  wst_t          st [NS];
  logic [NS-1:0] v;
  logic [NS-1:0] en;
  wst_t          first;

  function automatic logic signed [63:0] mul(logic signed [31:0] a, logic signed [31:0] b);
    return 64'(a) * 64'(b);
  endfunction

  // Q4.28 product back to Q4.28, round half up
  function automatic logic signed [39:0] rs28(logic signed [63:0] m);
    logic signed [63:0] w;
    w = (m + 64'sd134217728) >>> 28;
    return w[39:0];
  endfunction

  function automatic logic ovf32(logic signed [39:0] x);
    return (x > 40'(S32_MAX)) || (x < 40'(S32_MIN));
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [39:0] x);
    if (x > 40'(S32_MAX)) return S32_MAX;
    if (x < 40'(S32_MIN)) return S32_MIN;
    return x[31:0];
  endfunction

  function automatic logic [16:0] to_pix(logic signed [63:0] m, logic [15:0] c);
    logic signed [63:0] w;
    logic signed [23:0] p;
    w = (m + 64'sd137438953472) >>> 38;
    p = w[23:0] + $signed({8'd0, c});
    if (p > 24'sd32767)  return {1'b1, 16'sh7FFF};
    if (p < -24'sd32768) return {1'b1, 16'sh8000};
    return {1'b0, p[15:0]};
  endfunction

  function automatic wst_t step(int k, wst_t a, cfg_t c);
    wst_t               s;
    logic signed [39:0] x;
    logic signed [39:0] y;
    logic        [16:0] px;
    logic        [16:0] py;
    s = a;
    case (k)
      0: begin
        s.m0 = mul(a.dx, a.dx);
        s.m1 = mul(a.dy, a.dy);
        s.m2 = mul(a.dx, a.dy);
      end
      1: begin
        x = rs28(a.m0);
        s.dx2 = sat32(x);
        s.flag = s.flag | ovf32(x);
        x = rs28(a.m1);
        s.dy2 = sat32(x);
        s.flag = s.flag | ovf32(x);
        x = rs28(a.m2) <<< 1;
        s.dxdy2 = sat32(x);
        s.flag = s.flag | ovf32(x);
      end
      2: begin
        x = 40'(a.dx2) + 40'(a.dy2);
        s.r2 = sat32(x);
        s.flag = s.flag | ovf32(x);
      end
      3: begin
        x = 40'(a.r2) + (40'(a.dx2) <<< 1);
        y = 40'(a.r2) + (40'(a.dy2) <<< 1);
        s.ax = sat32(x);
        s.ay = sat32(y);
        s.flag = s.flag | ovf32(x) | ovf32(y);
        s.m0 = mul(c.k3, a.r2);
      end
      4: begin
        x = rs28(a.m0) + 40'(c.k2);
        s.t = sat32(x);
        s.flag = s.flag | ovf32(x);
      end
      5, 7: begin
        s.m0 = mul(a.t, a.r2);
      end
      6: begin
        x = rs28(a.m0) + 40'(c.k1);
        s.t = sat32(x);
        s.flag = s.flag | ovf32(x);
      end
      8: begin
        x = rs28(a.m0);
        s.t = sat32(x);
        s.flag = s.flag | ovf32(x);
      end
      9: begin
        x = 40'(a.t) + Q_ONE;
        s.kr = sat32(x);
        s.flag = s.flag | ovf32(x);
      end
      10: begin
        s.m0 = mul(a.dx, a.kr);
        s.m1 = mul(c.p2, a.ax);
        s.m2 = mul(c.p1, a.dxdy2);
        s.m3 = mul(a.dy, a.kr);
        s.m4 = mul(c.p1, a.ay);
        s.m5 = mul(c.p2, a.dxdy2);
      end
      11: begin
        x = rs28(a.m0) + rs28(a.m1) + rs28(a.m2);
        y = rs28(a.m3) + rs28(a.m4) + rs28(a.m5);
        s.ux = sat32(x);
        s.uy = sat32(y);
        s.flag = s.flag | ovf32(x) | ovf32(y);
      end
      12: begin
        s.m0 = 64'($signed({1'b0, c.focal_x})) * 64'(a.ux);
        s.m1 = 64'($signed({1'b0, c.focal_y})) * 64'(a.uy);
      end
      13: begin
        px = to_pix(a.m0, c.cx);
        py = to_pix(a.m1, c.cy);
        if (a.zero) begin
          s.ox   = '0;
          s.oy   = '0;
          s.flag = 1'b1;
        end else begin
          s.ox   = $signed(px[15:0]);
          s.oy   = $signed(py[15:0]);
          s.flag = a.flag | px[16] | py[16];
        end
      end
      default: ;
    endcase
    return s;
  endfunction

  always_comb begin
    first      = '0;
    first.dx   = in_data.dx;
    first.dy   = in_data.dy;
    first.flag = in_data.flag;
    first.zero = in_data.zero;
  end

  always_comb begin
    en[NS-1] = !v[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NS-1];
  assign warped_x  = st[NS-1].ox;
  assign warped_y  = st[NS-1].oy;
  assign saturated = st[NS-1].flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      st[0] <= step(0, first, cfg);
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        st[k] <= step(k, st[k-1], cfg);
      end
    end
  end

endmodule

// ----- verif/lens_distortion_apply_top_tb.sv -----
// Self-checking bench for the lens distortion pipeline: predicted warp vs DUT beats.
module lens_distortion_apply_top_tb;
  import lda_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  lda_in_if  pix_in ();
  lda_out_if pix_out ();

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  lens_distortion_apply_top uut (
    .clk(clk), .rst(rst), .pix_in(pix_in), .pix_out(pix_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // expected result of one pixel
  typedef struct packed {
    logic signed [15:0] wx;
    logic signed [15:0] wy;
    logic               sat;
  } warp_t;

  // predictor's own copy of the register file
  logic [23:0]        fx, fy;
  logic [15:0]        cxr, cyr;
  logic signed [31:0] k1r, k2r, k3r, p1r, p2r;

  warp_t expected_warps[$];
  int    errors = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  bit    hold_off = 1'b0;
  int    quiet_cycles = 0;
  localparam int WATCHDOG = 20000;
  localparam int PIPE_LAT = 24;

  // ---------------------------------------------------------------- predictor
  function automatic longint rshift(longint v, int s);
    longint w;
    w = v + (longint'(1) << (s - 1));
    return w >>> s;  // arithmetic shift is floor
  endfunction

  function automatic longint clip32(longint v, ref bit f);
    if (v > 64'sd2147483647) begin
      f = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      f = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint qmul28(longint a, longint b);
    return rshift(a * b, 28);
  endfunction

  // offset * 2^38 / focal, half away from zero, capped at 2^33
  function automatic longint norm_axis(longint d, logic [23:0] f, ref bit fl);
    logic [63:0] mag, q;
    mag = (d < 0 ? -d : d);
    mag = mag << 38;
    q = (mag + 64'(f / 2)) / 64'(f);
    if (q > (64'd1 << 33)) q = 64'd1 << 33;
    return clip32(d < 0 ? -longint'(q) : longint'(q), fl);
  endfunction

  function automatic longint back_to_pixel(longint u, logic [23:0] f, longint c, ref bit fl);
    longint v;
    v = rshift(longint'(f) * u, 38) + c;
    if (v > 32767) begin
      fl = 1'b1;
      return 32767;
    end
    if (v < -32768) begin
      fl = 1'b1;
      return -32768;
    end
    return v;
  endfunction

  function automatic warp_t predict_warp(logic signed [15:0] px, logic signed [15:0] py);
    warp_t  r;
    bit     fl;
    longint dx, dy, dx2, dy2, r2, dxy2, t, kr, ux, uy;
    fl = 1'b0;
    if (fx == 0 || fy == 0) begin
      r.wx = '0; r.wy = '0; r.sat = 1'b1;
      return r;
    end
    dx   = norm_axis(longint'(px) - longint'(cxr), fx, fl);
    dy   = norm_axis(longint'(py) - longint'(cyr), fy, fl);
    dx2  = clip32(qmul28(dx, dx), fl);
    dy2  = clip32(qmul28(dy, dy), fl);
    r2   = clip32(dx2 + dy2, fl);
    dxy2 = clip32(2 * qmul28(dx, dy), fl);
    t    = clip32(qmul28(k3r, r2) + k2r, fl);
    t    = clip32(qmul28(t, r2) + k1r, fl);
    t    = clip32(qmul28(t, r2), fl);
    kr   = clip32(t + (longint'(1) << 28), fl);
    ux   = clip32(qmul28(dx, kr) + qmul28(p2r, clip32(r2 + 2 * dx2, fl))
                  + qmul28(p1r, dxy2), fl);
    uy   = clip32(qmul28(dy, kr) + qmul28(p1r, clip32(r2 + 2 * dy2, fl))
                  + qmul28(p2r, dxy2), fl);
    r.wx  = 16'(back_to_pixel(ux, fx, longint'(cxr), fl));
    r.wy  = 16'(back_to_pixel(uy, fy, longint'(cyr), fl));
    r.sat = fl;
    return r;
  endfunction

  // ---------------------------------------------------------------- register port
  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FOCAL_X:   fx = val[23:0];
      REG_FOCAL_Y:   fy = val[23:0];
      REG_PRINCIPAL: begin
        cxr = val[15:0];
        cyr = val[31:16];
      end
      REG_K1:        k1r = val;
      REG_K2:        k2r = val;
      REG_K3:        k3r = val;
      REG_P1:        p1r = val;
      default:       p2r = val;
    endcase
  endtask

  // ---------------------------------------------------------------- sending side
  // one beat; valid stays high across back-to-back sends
  task automatic send_pixel(logic signed [15:0] px, logic signed [15:0] py);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in.valid   <= 1'b1;
    pix_in.pixel_x <= px;
    pix_in.pixel_y <= py;
    expected_warps.push_back(predict_warp(px, py));
    do @(posedge clk); while (!pix_in.ready);
  endtask

  task automatic end_burst();
    pix_in.valid <= 1'b0;
  endtask

  // wait for the pipe to drain before touching registers
  task automatic drain();
    int n;
    end_burst();
    n = 0;
    while (expected_warps.size() != 0 && n < 100000) begin
      @(posedge clk);
      n++;
    end
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- receiving side
  always @(posedge clk) begin
    if (rst) begin
      pix_out.ready <= 1'b0;
    end else begin
      pix_out.ready <= !hold_off &&
                       !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    warp_t e;
    if (!rst && pix_out.valid && pix_out.ready) begin
      if (expected_warps.size() == 0) begin
        $error("unexpected beat: x=%0d y=%0d sat=%0d",
               pix_out.warped_x, pix_out.warped_y, pix_out.saturated);
        errors++;
      end else begin
        e = expected_warps.pop_front();
        if (pix_out.warped_x !== e.wx) begin
          $error("warped_x: expected %0d actual %0d", e.wx, pix_out.warped_x);
          errors++;
        end
        if (pix_out.warped_y !== e.wy) begin
          $error("warped_y: expected %0d actual %0d", e.wy, pix_out.warped_y);
          errors++;
        end
        if (pix_out.saturated !== e.sat) begin
          $error("saturated: expected %0d actual %0d", e.sat, pix_out.saturated);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with no accepted beat on either side and no register access
  always @(posedge clk) begin
    if (rst || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("lens_distortion_apply_top_tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus helpers
  // mostly near the principal point, sometimes anywhere
  task automatic send_random(int n);
    logic signed [15:0] px, py;
    repeat (n) begin
      if ($urandom_range(3) == 0) begin
        px = 16'($urandom);
        py = 16'($urandom);
      end else begin
        px = 16'($signed({1'b0, cxr})
                 + $signed(16'($urandom_range(0, 8191)) - 16'sd4096));
        py = 16'($signed({1'b0, cyr})
                 + $signed(16'($urandom_range(0, 8191)) - 16'sd4096));
      end
      send_pixel(px, py);
    end
  endtask

  // small random distortion, realistic lens
  task automatic set_mild_lens();
    write_reg(REG_K1, 32'($signed($urandom_range(0, 1 << 27)) - (1 << 26)));
    write_reg(REG_K2, 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24)));
    write_reg(REG_K3, 32'($signed($urandom_range(0, 1 << 23)) - (1 << 22)));
    write_reg(REG_P1, 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20)));
    write_reg(REG_P2, 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20)));
  endtask

  task automatic set_idling(int s, int r);
    send_idle_pct  = s;
    recv_stall_pct = r;
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    send_pixel(16'sh0000, 16'sh0000);
    send_pixel(16'sh7FFF, 16'sh7FFF);
    send_pixel(-16'sh8000, -16'sh8000);
    send_pixel(16'sh7FFF, -16'sh8000);
    send_pixel($signed(cxr), $signed(cyr));
    drain();
    set_mild_lens();
    send_pixel($signed(cxr), $signed(cyr));
    send_pixel(16'sh5555, -16'sh5556);
    send_pixel(-16'sh2AAB, 16'sh2AAA);
    send_pixel(16'sh0010, 16'sh0020);
    drain();
    // extreme coefficients force intermediate saturation
    write_reg(REG_K1, 32'h7FFF_FFFF);
    write_reg(REG_K2, 32'h8000_0000);
    write_reg(REG_K3, 32'h7FFF_FFFF);
    write_reg(REG_P1, 32'h8000_0000);
    write_reg(REG_P2, 32'h7FFF_FFFF);
    send_pixel(16'sh7FFF, -16'sh8000);
    send_pixel(16'sh1100, 16'sh0E00);
    send_pixel(-16'sh8000, 16'sh7FFF);
    drain();
    // tiny and huge focal lengths, corner principal points
    write_reg(REG_FOCAL_X, 32'h0000_0001);
    write_reg(REG_FOCAL_Y, 32'h00FF_FFFF);
    write_reg(REG_PRINCIPAL, 32'hFFFF_0000);
    send_pixel(16'sh7FFF, 16'sh7FFF);
    send_pixel(-16'sh8000, 16'sh0000);
    drain();
    // zero focal length gives zero with the flag
    write_reg(REG_FOCAL_X, 32'h0000_0000);
    send_pixel(16'sh1234, 16'sh4321);
    drain();
    write_reg(REG_FOCAL_X, 32'(FOCAL_RESET));
    write_reg(REG_FOCAL_Y, 32'h0000_0000);
    write_reg(REG_PRINCIPAL, 32'h0000_FFFF);
    send_pixel(-16'sh0001, 16'sh0001);
    drain();
  endtask

  // restore a camera-like set-up and stream under each idling pattern
  task automatic test_random_phases();
    write_reg(REG_FOCAL_X, 32'(FOCAL_RESET));
    write_reg(REG_FOCAL_Y, 32'($urandom_range(24'h100000, 24'h800000)));
    write_reg(REG_PRINCIPAL, {CY_RESET, CX_RESET});
    set_mild_lens();
    set_idling(0, 0);   send_random(400);
    set_idling(83, 0);  send_random(300);
    set_idling(0, 83);  send_random(300);
    set_idling(20, 20); send_random(300);
    drain();
    set_idling(0, 0);
  endtask

  // random registers, extremes included
  task automatic test_random_registers();
    repeat (4) begin
      write_reg(REG_FOCAL_X, $urandom);
      write_reg(REG_FOCAL_Y, $urandom);
      write_reg(REG_PRINCIPAL, $urandom);
      write_reg(REG_K1, $urandom);
      write_reg(REG_K2, $urandom);
      write_reg(REG_K3, $urandom);
      write_reg(REG_P1, $urandom);
      write_reg(REG_P2, $urandom);
      set_idling(20, 20);
      send_random(100);
      drain();
    end
    set_idling(0, 0);
  endtask

  // long receiver hold-off while the sender keeps offering beats
  task automatic test_backpressure();
    write_reg(REG_FOCAL_X, 32'(FOCAL_RESET));
    write_reg(REG_FOCAL_Y, 32'(FOCAL_RESET));
    write_reg(REG_PRINCIPAL, {CY_RESET, CX_RESET});
    set_mild_lens();
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      send_random(220);
    join
    drain();
  endtask

  initial begin
    pix_in.valid   = 1'b0;
    pix_in.pixel_x = '0;
    pix_in.pixel_y = '0;
    fx = FOCAL_RESET; fy = FOCAL_RESET; cxr = CX_RESET; cyr = CY_RESET;
    k1r = '0; k2r = '0; k3r = '0; p1r = '0; p2r = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phases();
    test_random_registers();
    test_backpressure();
    repeat (PIPE_LAT + 8) @(posedge clk);
    if (errors == 0 && expected_warps.size() == 0) begin
      $display("lens_distortion_apply_top_tb passed");
    end else begin
      $display("lens_distortion_apply_top_tb failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/lda_pkg.sv
design/lda_if.sv
design/lda_cfg.sv
design/lda_norm.sv
design/lda_warp.sv
design/lens_distortion_apply_top.sv
verif/lens_distortion_apply_top_tb.sv
